// ===== rtl/hpct_pkg.sv =====
`default_nettype none
package hpct_pkg;
	localparam int SETS = 256;
	localparam int WAYS = 4;
	localparam int SET_W = $clog2(SETS);
	localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam logic [31:0] DEFAULT_THRESHOLD = 32'd50;
	localparam logic [63:0] MIX_MUL = 64'hFF51AFD7ED558CCD;
	localparam int MIX_SHIFT = 33;
	localparam logic [10:0] TOTAL_MAX = 11'd2047;

	localparam logic [1:0] ACT_HIT = 2'd0;
	localparam logic [1:0] ACT_BLACK = 2'd1;

	// one way of a set as stored in the memory: key, count and flags
	typedef struct packed {
		logic [63:0] tag;
		logic [31:0] count;
		logic        valid;
		logic        black;
	} way_t;

	// request moving from the hash unit to the table
	typedef struct packed {
		logic [1:0]       action;
		logic [63:0]      pc;
		logic [SET_W-1:0] set_idx;
	} req_t;

	// result item
	typedef struct packed {
		logic [10:0] blacklist_total;
		logic [10:0] entry_total;
		logic        dropped;
		logic        found;
		logic        is_blacklisted;
		logic [31:0] hit_count;
		logic        triggered;
	} res_t;
endpackage
`default_nettype wire

// ===== rtl/hpct_hash.sv =====
`default_nettype none
// Address mixer: xor-shift, 64-bit multiply from three 32x32 partial products
// (high-by-high omitted), xor-shift, set mask. One request at a time.
module hpct_hash (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [1:0]        action,
	input  wire logic [63:0]       pc,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output hpct_pkg::req_t         out_req
);
	logic [1:0]  phase_q;
	logic [63:0] x_q;
	logic [1:0]  act_q;
	logic [63:0] pc_q;
	logic [63:0] lo_q;
	logic [31:0] cross_q;
	logic [63:0] prod;
	logic [63:0] mixed;
	logic [63:0] pp_a;
	logic [31:0] pp_b;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_MUL1 = 2'd1;
	localparam logic [1:0] PH_MUL2 = 2'd2;
	localparam logic [1:0] PH_DONE = 2'd3;

	assign in_ready = (phase_q == PH_IDLE);
	assign out_valid = (phase_q == PH_DONE);

	// partial products; the high-by-high one never reaches the low 64 bits
	assign pp_a = {32'd0, x_q[31:0]} * {32'd0, hpct_pkg::MIX_MUL[31:0]};
	assign pp_b = x_q[63:32] * hpct_pkg::MIX_MUL[31:0];
	assign prod = lo_q + {cross_q, 32'd0};
	assign mixed = prod ^ (prod >> hpct_pkg::MIX_SHIFT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else begin
			case (phase_q)
				PH_IDLE: if (in_valid) phase_q <= PH_MUL1;
				PH_MUL1: phase_q <= PH_MUL2;
				PH_MUL2: phase_q <= PH_DONE;
				PH_DONE: if (out_ready) phase_q <= PH_IDLE;
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (phase_q == PH_IDLE && in_valid) begin
			x_q <= pc ^ (pc >> hpct_pkg::MIX_SHIFT);
			act_q <= action;
			pc_q <= pc;
		end
		if (phase_q == PH_MUL1) begin
			lo_q <= pp_a;
			cross_q <= pp_b;
		end
		if (phase_q == PH_MUL2) begin
			cross_q <= cross_q + x_q[31:0] * hpct_pkg::MIX_MUL[63:32];
		end
		if (phase_q == PH_DONE && out_ready) begin
			x_q <= x_q;
		end
	end

	always_comb begin
		out_req.action = act_q;
		out_req.pc = pc_q;
		out_req.set_idx = mixed[hpct_pkg::SET_W-1:0];
	end
endmodule
`default_nettype wire

// ===== rtl/hpct_table.sv =====
`default_nettype none
// Set store: one row of WAYS ways per set in a synchronous memory, with the
// valid and blacklist bits in the row. Read on accept; compare and write
// back when the output is free. Reset starts a clearing pass over all sets.
module hpct_table (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  hpct_pkg::req_t     req,
	input  wire logic [31:0]   threshold,
	output logic               res_valid,
	input  wire logic          res_ready,
	output hpct_pkg::res_t     res
);
	hpct_pkg::way_t mem_q [hpct_pkg::SETS][hpct_pkg::WAYS];
	hpct_pkg::way_t rd_s1 [hpct_pkg::WAYS];
	logic         busy_s1;
	hpct_pkg::req_t req_s1;
	logic         res_valid_q;
	hpct_pkg::res_t res_q;
	logic [10:0]  ent_q;
	logic [10:0]  blk_q;
	logic         clr_q;
	logic [hpct_pkg::SET_W-1:0] clr_idx_q;

	logic                         hit;
	logic                         has_free;
	logic [hpct_pkg::WAY_W-1:0]   hit_w;
	logic [hpct_pkg::WAY_W-1:0]   free_w;
	logic [hpct_pkg::WAY_W-1:0]   sel_w;
	logic                         present;
	logic                         create;
	logic                         is_hit_act;
	logic                         is_blk_act;
	logic [31:0]                  cnt_old;
	logic [31:0]                  cnt_new;
	logic                         blk_old;
	logic                         blk_new;
	logic                         trig;
	logic                         wr;
	logic                         mark;
	logic [31:0]                  th;
	logic                         step;

	assign req_ready = !clr_q && !busy_s1 && !(res_valid_q && !res_ready);
	assign step = busy_s1 && (!res_valid_q || res_ready);

	// tag compare and free-way search
	always_comb begin
		hit = 1'b0;
		has_free = 1'b0;
		hit_w = '0;
		free_w = '0;
		for (int w = 0; w < hpct_pkg::WAYS; w++) begin
			if (rd_s1[w].valid) begin
				if (!hit && rd_s1[w].tag == req_s1.pc) begin
					hit = 1'b1;
					hit_w = hpct_pkg::WAY_W'(w);
				end
			end else if (!has_free) begin
				has_free = 1'b1;
				free_w = hpct_pkg::WAY_W'(w);
			end
		end
	end

	always_comb begin
		is_hit_act = (req_s1.action == hpct_pkg::ACT_HIT);
		is_blk_act = (req_s1.action == hpct_pkg::ACT_BLACK);
		create = (req_s1.pc != 64'd0) && !hit && (is_hit_act || is_blk_act) && has_free;
		present = (req_s1.pc != 64'd0) && (hit || create);
		sel_w = hit ? hit_w : free_w;
		cnt_old = create ? 32'd0 : rd_s1[sel_w].count;
		blk_old = create ? 1'b0 : rd_s1[sel_w].black;
		th = (threshold != 32'd0) ? threshold : hpct_pkg::DEFAULT_THRESHOLD;
		cnt_new = cnt_old;
		trig = 1'b0;
		mark = 1'b0;
		if (present && is_hit_act) begin
			if (cnt_old != 32'hFFFFFFFF) cnt_new = cnt_old + 32'd1;
			if (!blk_old && cnt_new >= th) begin
				trig = 1'b1;
				mark = 1'b1;
			end
		end else if (present && is_blk_act && !blk_old) begin
			mark = 1'b1;
		end
		blk_new = blk_old || mark;
		wr = present && (is_hit_act || is_blk_act);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
			res_valid_q <= 1'b0;
			ent_q <= '0;
			blk_q <= '0;
			clr_q <= 1'b1;
			clr_idx_q <= '0;
		end else begin
			// clearing pass, one set per cycle
			if (clr_q) begin
				if (clr_idx_q == hpct_pkg::SET_W'(hpct_pkg::SETS - 1)) clr_q <= 1'b0;
				else clr_idx_q <= clr_idx_q + 1'b1;
			end
			if (req_valid && req_ready) busy_s1 <= 1'b1;
			else if (step) busy_s1 <= 1'b0;
			if (step) res_valid_q <= 1'b1;
			else if (res_ready) res_valid_q <= 1'b0;
			if (step) begin
				if (create && ent_q != hpct_pkg::TOTAL_MAX) ent_q <= ent_q + 11'd1;
				if (mark && blk_q != hpct_pkg::TOTAL_MAX) blk_q <= blk_q + 11'd1;
			end
		end
	end

	// memory clear, read and write-back
	always_ff @(posedge clk) begin
		if (clr_q) begin
			for (int w = 0; w < hpct_pkg::WAYS; w++) mem_q[clr_idx_q][w] <= '0;
		end
		if (req_valid && req_ready) begin
			req_s1 <= req;
			for (int w = 0; w < hpct_pkg::WAYS; w++) rd_s1[w] <= mem_q[req.set_idx][w];
		end
		if (step && wr) begin
			mem_q[req_s1.set_idx][sel_w] <= '{tag: req_s1.pc, count: cnt_new,
				valid: 1'b1, black: blk_new};
		end
		if (step) begin
			res_q.triggered <= trig;
			res_q.hit_count <= present ? cnt_new : 32'd0;
			res_q.is_blacklisted <= present && blk_new;
			res_q.found <= present;
			res_q.dropped <= (req_s1.pc != 64'd0) && !hit && (is_hit_act || is_blk_act)
				&& !has_free;
			res_q.entry_total <= create && ent_q != hpct_pkg::TOTAL_MAX ? ent_q + 11'd1 : ent_q;
			res_q.blacklist_total <= mark && blk_q != hpct_pkg::TOTAL_MAX ? blk_q + 11'd1 : blk_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res = res_q;
endmodule
`default_nettype wire

// ===== rtl/hot_pc_counter_table_top.sv =====
`default_nettype none
// Hot address counter table.
// Input stream s_axis: tdata = action[1:0], pc[65:2] (72 bits, zero filled).
// Output stream m_axis: one result per request, tdata as listed at the port.
// cfg_we/cfg_wdata write hit_threshold (0 selects the default of 50); write
// only while no request is in flight.
// Path from accept to result: the mixer (64-bit multiply as partial products
// in states MUL1 and MUL2, then the final add), a hand-off that reads the
// set row, then compare and write-back into the output register.
// The mixer handles one request at a time and takes the next request only
// once the table has taken the current one.
// Reset clears both totals and the threshold at once, then a clearing pass
// zeroes the flag bits of all 256 sets; the mixer may take one request
// meanwhile and holds it until the pass ends.
// A stalled receiver holds the result in the output register; the mixer
// may finish one further request and then stops taking input.
module hot_pc_counter_table_top (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [31:0]  cfg_wdata,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [71:0]  s_axis_tdata,  // action[1:0], pc[65:2]
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// triggered[0], hit_count[32:1], is_blacklisted[33], found[34],
	// dropped[35], entry_total[46:36], blacklist_total[57:47]
	output logic [63:0]       m_axis_tdata
);
	logic [31:0] thr_q;
	logic        h_valid;
	logic        h_ready;
	hpct_pkg::req_t h_req;
	hpct_pkg::res_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) thr_q <= '0;
		else if (cfg_we) thr_q <= cfg_wdata;
	end

	hpct_hash u_hash (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.action(s_axis_tdata[1:0]), .pc(s_axis_tdata[65:2]),
		.out_valid(h_valid), .out_ready(h_ready), .out_req(h_req)
	);

	hpct_table u_table (
		.clk(clk), .arst_n(arst_n),
		.req_valid(h_valid), .req_ready(h_ready), .req(h_req),
		.threshold(thr_q),
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res)
	);

	assign m_axis_tdata = {6'd0, res};

	// a dropped request never reports an entry
	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(res.dropped && res.found)) else $error("drop with entry");
	// trigger implies blacklisted and found
	a_trig: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res.triggered |-> res.is_blacklisted && res.found)
		else $error("trigger without mark");
	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result changed under stall");
endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] ACT_LOOKUP = 2'd2;
	localparam logic [1:0] ACT_SPARE = 2'd3;

	// table model: tag/count/flags per way, totals, threshold
	class hot_table_scoreboard;
		logic [63:0] tags [hpct_pkg::SETS*hpct_pkg::WAYS];
		logic [31:0] counts [hpct_pkg::SETS*hpct_pkg::WAYS];
		bit valid [hpct_pkg::SETS*hpct_pkg::WAYS];
		bit black [hpct_pkg::SETS*hpct_pkg::WAYS];
		logic [10:0] entries;
		logic [10:0] blacks;
		logic [31:0] threshold;
		hpct_pkg::res_t pending [$];
		int errors;
		int checked;

		function void clear();
			foreach (valid[i]) begin
				valid[i] = 0;
				black[i] = 0;
			end
			entries = 0;
			blacks = 0;
			threshold = 0;
			pending.delete();
		endfunction

		function logic [hpct_pkg::SET_W-1:0] set_of(logic [63:0] pc);
			logic [63:0] x;
			x = pc ^ (pc >> 33);
			x = x * 64'hFF51AFD7ED558CCD;
			x = x ^ (x >> 33);
			return x[hpct_pkg::SET_W-1:0];
		endfunction

		function void mark_black(int s);
			black[s] = 1;
			if (blacks != 11'd2047) blacks++;
		endfunction

		// note an accepted request and queue its expected result
		function void note_request(logic [1:0] act, logic [63:0] pc);
			hpct_pkg::res_t r;
			int base, s, slot, free_slot;
			bit hit, has_free;
			logic [31:0] th;
			r = '0;
			hit = 0;
			has_free = 0;
			slot = 0;
			free_slot = 0;
			if (pc != 0) begin
				base = set_of(pc) * hpct_pkg::WAYS;
				for (int w = 0; w < hpct_pkg::WAYS; w++) begin
					s = base + w;
					if (valid[s]) begin
						if (!hit && tags[s] == pc) begin
							hit = 1;
							slot = s;
						end
					end else if (!has_free) begin
						has_free = 1;
						free_slot = s;
					end
				end
				if (!hit && (act == hpct_pkg::ACT_HIT || act == hpct_pkg::ACT_BLACK)) begin
					if (has_free) begin
						slot = free_slot;
						tags[slot] = pc;
						counts[slot] = 0;
						valid[slot] = 1;
						black[slot] = 0;
						if (entries != 11'd2047) entries++;
						hit = 1;
					end else begin
						r.dropped = 1;
					end
				end
				if (hit) begin
					if (act == hpct_pkg::ACT_HIT) begin
						th = (threshold != 0) ? threshold : hpct_pkg::DEFAULT_THRESHOLD;
						if (counts[slot] != 32'hFFFFFFFF) counts[slot]++;
						if (!black[slot] && counts[slot] >= th) begin
							mark_black(slot);
							r.triggered = 1;
						end
					end else if (act == hpct_pkg::ACT_BLACK) begin
						if (!black[slot]) mark_black(slot);
					end
					r.found = 1;
					r.hit_count = counts[slot];
					r.is_blacklisted = black[slot];
				end
			end
			r.entry_total = entries;
			r.blacklist_total = blacks;
			pending.push_back(r);
		endfunction

		function void report(string what, logic [63:0] got, logic [63:0] want);
			$display("mismatch %s: got %0h expected %0h", what, got, want);
			errors++;
		endfunction

		// compare one result field by field with the oldest expectation
		function void check_result(hpct_pkg::res_t got);
			hpct_pkg::res_t want;
			checked++;
			if (pending.size() == 0) begin
				report("unexpected result", got, 0);
				return;
			end
			want = pending.pop_front();
			if (got.triggered !== want.triggered)
				report("triggered", got.triggered, want.triggered);
			if (got.hit_count !== want.hit_count)
				report("hit_count", got.hit_count, want.hit_count);
			if (got.is_blacklisted !== want.is_blacklisted)
				report("is_blacklisted", got.is_blacklisted, want.is_blacklisted);
			if (got.found !== want.found) report("found", got.found, want.found);
			if (got.dropped !== want.dropped) report("dropped", got.dropped, want.dropped);
			if (got.entry_total !== want.entry_total)
				report("entry_total", got.entry_total, want.entry_total);
			if (got.blacklist_total !== want.blacklist_total)
				report("blacklist_total", got.blacklist_total, want.blacklist_total);
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [31:0] cfg_wdata = '0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [71:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [63:0] m_axis_tdata;

	hot_table_scoreboard table_sb;
	bit hold_off = 0;
	int requests_sent = 0;
	int triggers_seen = 0;
	int drops_seen = 0;
	logic [63:0] pc_pool [48];

	always #4 clk = ~clk;

	hot_pc_counter_table_top u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
	);

	function int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 40) return 0;
		if (p < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// offer one request and wait for acceptance; valid stays up when no gap follows
	task automatic send_request(logic [1:0] act, logic [63:0] pc);
		int g;
		g = gap_len();
		if (g > 0) begin
			s_axis_tvalid <= 0;
			repeat (g) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {6'b0, pc, act};
		do @(posedge clk); while (!s_axis_tready);
		table_sb.note_request(act, pc);
		requests_sent++;
	endtask

	// wait until every result is back, then let the pipeline drain
	task automatic drain();
		int n;
		n = 0;
		s_axis_tvalid <= 0;
		while (table_sb.pending.size() != 0 && n < 200000) begin
			@(posedge clk);
			n++;
		end
		repeat (20) @(posedge clk);
	endtask

	task automatic write_threshold(logic [31:0] v);
		cfg_we <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
		table_sb.threshold = v;
	endtask

	// receiver: random stalls, plus one long hold-off on request
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				table_sb.check_result(hpct_pkg::res_t'(m_axis_tdata[57:0]));
				if (m_axis_tdata[0]) triggers_seen++;
				if (m_axis_tdata[35]) drops_seen++;
			end
			m_axis_tready <= hold_off ? 1'b0 : ($urandom_range(0, 9) < 7);
		end
	end

	function logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function logic [1:0] rand_act();
		int p;
		p = $urandom_range(0, 99);
		if (p < 60) return hpct_pkg::ACT_HIT;
		if (p < 75) return hpct_pkg::ACT_BLACK;
		if (p < 95) return ACT_LOOKUP;
		return ACT_SPARE;
	endfunction

	function logic [63:0] pick_pc();
		int p;
		p = $urandom_range(0, 99);
		if (p < 70) return pc_pool[$urandom_range(0, 47)];
		if (p < 73) return 64'd0;
		if (p < 76) return 64'hFFFFFFFFFFFFFFFF;
		return rand64();
	endfunction

	initial begin
		table_sb = new();
		table_sb.clear();
		repeat (12) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// directed: zero address, extremes, every action, default threshold
		send_request(hpct_pkg::ACT_HIT, 64'd0);
		send_request(ACT_LOOKUP, 64'hFFFFFFFFFFFFFFFF);
		send_request(hpct_pkg::ACT_HIT, 64'hFFFFFFFFFFFFFFFF);
		send_request(hpct_pkg::ACT_BLACK, 64'h8000000000000001);
		send_request(hpct_pkg::ACT_HIT, 64'h8000000000000001);
		send_request(ACT_SPARE, 64'h8000000000000001);
		send_request(hpct_pkg::ACT_BLACK, 64'h5555AAAA5555AAAA);
		send_request(ACT_LOOKUP, 64'h1234);
		for (int i = 0; i < 51; i++) send_request(hpct_pkg::ACT_HIT, 64'h1);
		drain();

		// threshold one: the first hit on each stored address triggers; fill one set past full
		write_threshold(32'd1);
		begin
			logic [63:0] p;
			logic [hpct_pkg::SET_W-1:0] s0;
			int n;
			s0 = table_sb.set_of(64'hABCD);
			n = 0;
			p = 64'hABCD;
			while (n < hpct_pkg::WAYS + 2) begin
				if (table_sb.set_of(p) == s0) begin
					send_request(hpct_pkg::ACT_HIT, p);
					n++;
				end
				p = p + 64'd977;
			end
			send_request(hpct_pkg::ACT_BLACK, p - 64'd977);
			send_request(ACT_LOOKUP, p - 64'd977);
		end
		drain();

		// saturation corner: highest threshold never triggers
		write_threshold(32'hFFFFFFFF);
		for (int i = 0; i < 48; i++) pc_pool[i] = rand64();
		for (int i = 0; i < 400; i++) send_request(rand_act(), pick_pc());

		// long receiver stall while the sender keeps offering requests
		fork
			begin
				hold_off = 1;
				repeat (300) @(posedge clk);
				hold_off = 0;
			end
			for (int i = 0; i < 30; i++) send_request(rand_act(), pick_pc());
		join
		drain();

		write_threshold(32'd0);
		for (int i = 0; i < 48; i++) pc_pool[i] = rand64();
		for (int i = 0; i < 250; i++) send_request(rand_act(), pick_pc());
		drain();

		write_threshold($urandom_range(2, 8));
		for (int i = 0; i < 250; i++) send_request(rand_act(), pick_pc());
		drain();

		$display("covered %0d requests, %0d results, %0d triggers, %0d drops",
			requests_sent, table_sb.checked, triggers_seen, drops_seen);
		$display("thresholds default, 1, max and small random; full sets and long stall");
		if (table_sb.errors == 0 && table_sb.pending.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("FAIL");
		$finish;
	end
endmodule
`default_nettype wire
